// ===== rtl/rti_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_pkg
// Types, widths and register codes shared by the ray/triangle intersection
// pipeline.
// ----------------------------------------------------------------------------
package rti_pkg;

	localparam int FRAC_BITS = 16;

	localparam int CW  = 32;              // coordinate width
	localparam int EW  = CW + 1;          // edge / offset width
	localparam int XW  = 2 * EW + 1;      // cross product component width
	localparam int XLO = 34;              // low slice of a cross component
	localparam int HW  = EW + XW - XLO;   // high partial product width
	localparam int LW  = EW + XLO + 1;    // low partial product width
	localparam int PW  = EW + XW;         // full dot term width
	localparam int DW  = PW + 2;          // determinant width
	localparam int NW  = DW + FRAC_BITS;  // scaled numerator width
	localparam int QW  = 32;              // quotient bits produced
	localparam int RW  = DW + QW + 1;     // divider remainder width
	localparam int AW  = 3;               // register index width

	localparam logic [AW-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [AW-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [AW-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [AW-1:0] REG_DIR_X    = 3'd3;
	localparam logic [AW-1:0] REG_DIR_Y    = 3'd4;
	localparam logic [AW-1:0] REG_DIR_Z    = 3'd5;

	// component rotation for cross products
	localparam int NXT [3] = '{1, 2, 0};
	localparam int PRV [3] = '{2, 0, 1};

	typedef struct packed {
		logic signed [CW-1:0] a_x;
		logic signed [CW-1:0] a_y;
		logic signed [CW-1:0] a_z;
		logic signed [CW-1:0] b_x;
		logic signed [CW-1:0] b_y;
		logic signed [CW-1:0] b_z;
		logic signed [CW-1:0] c_x;
		logic signed [CW-1:0] c_y;
		logic signed [CW-1:0] c_z;
	} rti_in_t;

	typedef struct packed {
		logic                 hit;
		logic                 parallel;
		logic signed [CW-1:0] distance;
	} rti_out_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} rti_vec_t;

	typedef struct packed {
		logic valid;
		logic parallel;
		logic hit;
		logic neg;
		logic ovf;
	} rti_side_t;

	function automatic logic signed [EW-1:0] sext(input logic signed [CW-1:0] x);
		return {x[CW-1], x};
	endfunction

endpackage

// ===== rtl/ray_triangle_intersection.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_intersection
// Cramer's-rule ray/triangle test in signed fixed point against one ray held
// in configuration registers.
// ----------------------------------------------------------------------------
// Takes one triangle every clock; busy never rises. Each item's result shows
// on result with done high for one cycle, after six stages of determinant
// arithmetic, two of sign handling and inside test, 32 restoring-divider
// stages (one quotient bit each) and an output register.
// Results cannot be held off, so take them on the cycle done is high.
// Write the ray registers only while no item is in flight.
module ray_triangle_intersection (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  rti_pkg::rti_in_t        triangle,
	output logic                    done,
	output rti_pkg::rti_out_t       result,
	input  logic                    cfg_wr_en,
	input  logic [rti_pkg::AW-1:0]  cfg_addr,
	input  logic [rti_pkg::CW-1:0]  cfg_wdata
);
	import rti_pkg::*;

	rti_vec_t             origin_q, dir_q;
	logic                 det_valid;
	logic signed [DW-1:0] det_m, det_l, det_a, det_b;
	rti_side_t            side;
	logic [QW-1:0]        quot;
	logic signed [CW-1:0] sat_distance;
	logic                 done_s;
	rti_out_t             result_s;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
			dir_q    <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_ORIGIN_X: origin_q.x <= cfg_wdata;
				REG_ORIGIN_Y: origin_q.y <= cfg_wdata;
				REG_ORIGIN_Z: origin_q.z <= cfg_wdata;
				REG_DIR_X:    dir_q.x    <= cfg_wdata;
				REG_DIR_Y:    dir_q.y    <= cfg_wdata;
				REG_DIR_Z:    dir_q.z    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	rti_det u_det (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.triangle  (triangle),
		.origin    (origin_q),
		.dir       (dir_q),
		.out_valid (det_valid),
		.det_m     (det_m),
		.det_l     (det_l),
		.det_a     (det_a),
		.det_b     (det_b)
	);

	rti_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (det_valid),
		.det_m    (det_m),
		.det_l    (det_l),
		.det_a    (det_a),
		.det_b    (det_b),
		.side_out (side),
		.quot     (quot)
	);

	// saturate to the signed range, negate toward zero
	always_comb begin
		if (side.parallel) begin
			sat_distance = '0;
		end else if (side.neg) begin
			sat_distance = (side.ovf || quot[QW-1]) ? {1'b1, {(CW-1){1'b0}}} : -$signed(quot);
		end else begin
			sat_distance = (side.ovf || quot == {1'b0, {(QW-1){1'b1}}} || quot[QW-1])
				? {1'b0, {(CW-1){1'b1}}} : $signed(quot);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s <= 1'b0;
		end else begin
			done_s <= side.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_s.hit      <= side.hit;
		result_s.parallel <= side.parallel;
		result_s.distance <= sat_distance;
	end

	assign done   = done_s;
	assign result = result_s;

endmodule

// ===== rtl/rti_det.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_det
// Six-stage determinant pipeline: edges, cross products, split dot products,
// and the four sums det[U,V,-D], det[U,V,T], det[T,V,-D], det[U,T,-D].
// ----------------------------------------------------------------------------
module rti_det (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  rti_pkg::rti_in_t           triangle,
	input  rti_pkg::rti_vec_t          origin,
	input  rti_pkg::rti_vec_t          dir,
	output logic                       out_valid,
	output logic signed [rti_pkg::DW-1:0] det_m,
	output logic signed [rti_pkg::DW-1:0] det_l,
	output logic signed [rti_pkg::DW-1:0] det_a,
	output logic signed [rti_pkg::DW-1:0] det_b
);
	import rti_pkg::*;

	logic signed [EW-1:0]   u_s1 [3], v_s1 [3], t_s1 [3], nd_s1 [3];
	logic signed [EW-1:0]   u_s2 [3], t_s2 [3], u_s3 [3], t_s3 [3];
	logic signed [2*EW-1:0] pa_s2 [3][3], pb_s2 [3][3];
	logic signed [XW-1:0]   x_s3 [3][3];
	logic signed [EW-1:0]   dot_a [4][3];
	logic signed [XW-1:0]   dot_x [4][3];
	logic signed [HW-1:0]   hi_s4 [4][3];
	logic signed [LW-1:0]   lo_s4 [4][3];
	logic signed [PW-1:0]   pr_s5 [4][3];
	logic signed [DW-1:0]   det_s6 [4];
	logic                   v1_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
		end else begin
			v1_s1 <= in_valid;
			v_s2  <= v1_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
		end
	end

	// edges U = B - A, V = C - A, offset T = O - A, and -D
	always_ff @(posedge clk) begin
		u_s1[0]  <= sext(triangle.b_x) - sext(triangle.a_x);
		u_s1[1]  <= sext(triangle.b_y) - sext(triangle.a_y);
		u_s1[2]  <= sext(triangle.b_z) - sext(triangle.a_z);
		v_s1[0]  <= sext(triangle.c_x) - sext(triangle.a_x);
		v_s1[1]  <= sext(triangle.c_y) - sext(triangle.a_y);
		v_s1[2]  <= sext(triangle.c_z) - sext(triangle.a_z);
		t_s1[0]  <= sext(origin.x) - sext(triangle.a_x);
		t_s1[1]  <= sext(origin.y) - sext(triangle.a_y);
		t_s1[2]  <= sext(origin.z) - sext(triangle.a_z);
		nd_s1[0] <= -sext(dir.x);
		nd_s1[1] <= -sext(dir.y);
		nd_s1[2] <= -sext(dir.z);
	end

	// cross products V x -D, V x T, T x -D: products, then differences
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pa_s2[0][i] <= v_s1[NXT[i]] * nd_s1[PRV[i]];
			pb_s2[0][i] <= v_s1[PRV[i]] * nd_s1[NXT[i]];
			pa_s2[1][i] <= v_s1[NXT[i]] * t_s1[PRV[i]];
			pb_s2[1][i] <= v_s1[PRV[i]] * t_s1[NXT[i]];
			pa_s2[2][i] <= t_s1[NXT[i]] * nd_s1[PRV[i]];
			pb_s2[2][i] <= t_s1[PRV[i]] * nd_s1[NXT[i]];
			u_s2[i]     <= u_s1[i];
			t_s2[i]     <= t_s1[i];
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			for (int i = 0; i < 3; i++) begin
				x_s3[c][i] <= XW'(pa_s2[c][i]) - XW'(pb_s2[c][i]);
			end
		end
		for (int i = 0; i < 3; i++) begin
			u_s3[i] <= u_s2[i];
			t_s3[i] <= t_s2[i];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dot_a[0][i] = u_s3[i];
			dot_x[0][i] = x_s3[0][i];
			dot_a[1][i] = u_s3[i];
			dot_x[1][i] = x_s3[1][i];
			dot_a[2][i] = t_s3[i];
			dot_x[2][i] = x_s3[0][i];
			dot_a[3][i] = u_s3[i];
			dot_x[3][i] = x_s3[2][i];
		end
	end

	// split each 33 x 67 product into a high and a low partial product
	always_ff @(posedge clk) begin
		for (int d = 0; d < 4; d++) begin
			for (int i = 0; i < 3; i++) begin
				hi_s4[d][i] <= dot_a[d][i] * $signed(dot_x[d][i][XW-1:XLO]);
				lo_s4[d][i] <= dot_a[d][i] * $signed({1'b0, dot_x[d][i][XLO-1:0]});
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int d = 0; d < 4; d++) begin
			for (int i = 0; i < 3; i++) begin
				pr_s5[d][i] <= (PW'(hi_s4[d][i]) <<< XLO) + PW'(lo_s4[d][i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int d = 0; d < 4; d++) begin
			det_s6[d] <= DW'(pr_s5[d][0]) + DW'(pr_s5[d][1]) + DW'(pr_s5[d][2]);
		end
	end

	assign out_valid = v_s6;
	assign det_m     = det_s6[0];
	assign det_l     = det_s6[1];
	assign det_a     = det_s6[2];
	assign det_b     = det_s6[3];

endmodule

// ===== rtl/rti_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_div
// Sign handling, inside test and a 32-stage restoring divider that forms
// |det_l| * 2^FRAC_BITS / |det_m|, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rti_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic signed [rti_pkg::DW-1:0] det_m,
	input  logic signed [rti_pkg::DW-1:0] det_l,
	input  logic signed [rti_pkg::DW-1:0] det_a,
	input  logic signed [rti_pkg::DW-1:0] det_b,
	output rti_pkg::rti_side_t            side_out,
	output logic [rti_pkg::QW-1:0]        quot
);
	import rti_pkg::*;

	logic                 m_neg;
	logic [DW-1:0]        l_abs;
	rti_side_t            side_s7;
	logic [DW-1:0]        mag_s7;
	logic [NW-1:0]        num_s7;
	logic signed [DW-1:0] da_s7, db_s7;
	logic signed [DW:0]   ab_sum;

	rti_side_t            side_sd [QW+1];
	logic [RW-1:0]        rem_sd  [QW];
	logic [DW-1:0]        dv_sd   [QW];
	logic [QW-1:0]        q_sd    [QW+1];

	assign m_neg  = det_m[DW-1];
	assign l_abs  = det_l[DW-1] ? DW'(-det_l) : DW'(det_l);
	assign ab_sum = (DW+1)'(da_s7) + (DW+1)'(db_s7);

	// fold the sign of det_m into the hit test terms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s7 <= '0;
		end else begin
			side_s7.valid    <= in_valid;
			side_s7.parallel <= (det_m == '0);
			side_s7.neg      <= det_l[DW-1] ^ m_neg;
			side_s7.hit      <= 1'b0;
			side_s7.ovf      <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		mag_s7 <= m_neg ? DW'(-det_m) : DW'(det_m);
		num_s7 <= {l_abs, {FRAC_BITS{1'b0}}};
		da_s7  <= m_neg ? -det_a : det_a;
		db_s7  <= m_neg ? -det_b : det_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_sd[0] <= '0;
		end else begin
			side_sd[0].valid    <= side_s7.valid;
			side_sd[0].parallel <= side_s7.parallel;
			side_sd[0].neg      <= side_s7.neg;
			side_sd[0].hit      <= !side_s7.parallel && !da_s7[DW-1] && !db_s7[DW-1]
				&& ($signed({1'b0, mag_s7}) >= ab_sum);
			// quotient would need more than QW bits: saturate
			side_sd[0].ovf      <= RW'(num_s7) >= {1'b0, mag_s7, {QW{1'b0}}};
		end
	end

	always_ff @(posedge clk) begin
		rem_sd[0] <= RW'(num_s7);
		dv_sd[0]  <= mag_s7;
		q_sd[0]   <= '0;
	end

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [RW:0] trial;

		assign trial = {1'b0, rem_sd[k]} - ({1'b0, RW'(dv_sd[k])} << (QW - 1 - k));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_sd[k+1] <= '0;
			end else begin
				side_sd[k+1] <= side_sd[k];
			end
		end

		always_ff @(posedge clk) begin
			q_sd[k+1] <= {q_sd[k][QW-2:0], !trial[RW]};
		end

		// the last stage only needs its quotient bit
		if (k < QW - 1) begin : g_fwd
			always_ff @(posedge clk) begin
				rem_sd[k+1] <= trial[RW] ? rem_sd[k] : trial[RW-1:0];
				dv_sd[k+1]  <= dv_sd[k];
			end
		end
	end

	assign side_out = side_sd[QW];
	assign quot     = q_sd[QW];

endmodule

// ===== rtl/rti_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_props
// Port-level checks on the intersection block: result form and fixed latency.
// ----------------------------------------------------------------------------
module rti_props (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    done,
	input rti_pkg::rti_out_t       result
);
	import rti_pkg::*;

	localparam int LAT = 41;

	logic [5:0] since_rst_q;

	// count cycles since reset so latency checks start with a full pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_rst_q <= '0;
		end else if (since_rst_q != 6'(LAT)) begin
			since_rst_q <= since_rst_q + 6'd1;
		end
	end

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	a_parallel_form: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.parallel |-> !result.hit && result.distance == '0)
		else $error("parallel result with hit or distance");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		since_rst_q == 6'(LAT) |-> done == $past(start && !busy, LAT))
		else $error("result strobe does not follow its item");

	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		since_rst_q < 6'(LAT) |-> !done)
		else $error("result strobe before any item could finish");

endmodule

bind ray_triangle_intersection rti_props u_rti_props (.*);

// ===== bench/rti_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_checker
// Watches the ray register writes, the triangle items and the results of the
// ray/triangle block. It predicts each result with exact wide arithmetic and
// compares every result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module rti_checker (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  rti_pkg::rti_in_t        triangle,
	input  logic                    done,
	input  rti_pkg::rti_out_t       result,
	input  logic                    cfg_wr_en,
	input  logic [rti_pkg::AW-1:0]  cfg_addr,
	input  logic [rti_pkg::CW-1:0]  cfg_wdata,
	output int                      errors,
	output int                      pending
);
	import rti_pkg::*;

	typedef logic signed [127:0] wide_t;

	logic signed [CW-1:0] ray_org [3];
	logic signed [CW-1:0] ray_dir [3];
	rti_out_t             hit_q [$];

	// a . (b x c)
	function automatic wide_t triple(input wide_t a [3], input wide_t b [3], input wide_t c [3]);
		return a[0] * (b[1] * c[2] - b[2] * c[1])
		     + a[1] * (b[2] * c[0] - b[0] * c[2])
		     + a[2] * (b[0] * c[1] - b[1] * c[0]);
	endfunction

	function automatic rti_out_t predict(input rti_in_t t);
		wide_t           u [3];
		wide_t           v [3];
		wide_t           o [3];
		wide_t           nd [3];
		logic signed [CW-1:0] pa [3];
		logic signed [CW-1:0] pb [3];
		logic signed [CW-1:0] pc [3];
		wide_t           m, dl, da, db, num;
		logic [127:0]    q, num_mag, m_mag;
		logic            neg;
		rti_out_t        r;
		pa = '{t.a_x, t.a_y, t.a_z};
		pb = '{t.b_x, t.b_y, t.b_z};
		pc = '{t.c_x, t.c_y, t.c_z};
		for (int i = 0; i < 3; i++) begin
			u[i]  = wide_t'(pb[i]) - wide_t'(pa[i]);
			v[i]  = wide_t'(pc[i]) - wide_t'(pa[i]);
			o[i]  = wide_t'(ray_org[i]) - wide_t'(pa[i]);
			nd[i] = -wide_t'(ray_dir[i]);
		end
		m = triple(u, v, nd);
		r = '0;
		if (m == 0) begin
			r.parallel = 1'b1;
			return r;
		end
		dl = triple(u, v, o);
		da = triple(o, v, nd);
		db = triple(u, o, nd);
		num = dl <<< FRAC_BITS;
		num_mag = num[127] ? -num : num;
		m_mag = m[127] ? -m : m;
		q = num_mag / m_mag;
		neg = num[127] != m[127];
		if (neg)
			r.distance = (q >= 128'h8000_0000) ? 32'sh8000_0000 : -q[31:0];
		else
			r.distance = (q >= 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
		// fold the sign of the main determinant into the inside test
		if (m[127]) begin
			m = -m;
			da = -da;
			db = -db;
		end
		r.hit = (da >= 0) && (db >= 0) && (m - (da + db) >= 0);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rti_out_t exp_r;
		if (!arst_n) begin
			ray_org = '{0, 0, 0};
			ray_dir = '{0, 0, 0};
			hit_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_addr)
					REG_ORIGIN_X: ray_org[0] = cfg_wdata;
					REG_ORIGIN_Y: ray_org[1] = cfg_wdata;
					REG_ORIGIN_Z: ray_org[2] = cfg_wdata;
					REG_DIR_X:    ray_dir[0] = cfg_wdata;
					REG_DIR_Y:    ray_dir[1] = cfg_wdata;
					REG_DIR_Z:    ray_dir[2] = cfg_wdata;
					default: ;
				endcase
			end
			if (done) begin
				if (hit_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result hit=%0b parallel=%0b distance=%0d",
						$time, result.hit, result.parallel, result.distance);
				end else begin
					exp_r = hit_q.pop_front();
					if (result.hit !== exp_r.hit) begin
						errors++;
						$display("%0t: hit expected %0b actual %0b",
							$time, exp_r.hit, result.hit);
					end
					if (result.parallel !== exp_r.parallel) begin
						errors++;
						$display("%0t: parallel expected %0b actual %0b",
							$time, exp_r.parallel, result.parallel);
					end
					if (result.distance !== exp_r.distance) begin
						errors++;
						$display("%0t: distance expected %0d actual %0d",
							$time, exp_r.distance, result.distance);
					end
				end
			end
			if (start && !busy)
				hit_q.push_back(predict(triangle));
			pending = hit_q.size();
		end
	end

endmodule

// ===== bench/tb_ray_triangle_intersection.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_triangle_intersection
// Streams triangles against a series of ray settings, from edge cases to
// random and hit-biased triangles, with random gaps and drains.
// ----------------------------------------------------------------------------
module tb_ray_triangle_intersection;
	import rti_pkg::*;

	localparam int DRAIN_CYCLES = 60;
	localparam int IDLE_LIMIT   = 3000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	rti_in_t             triangle = '0;
	logic                done;
	rti_out_t            result;
	logic                cfg_wr_en = 1'b0;
	logic [AW-1:0]       cfg_addr = '0;
	logic [CW-1:0]       cfg_wdata = '0;
	int                  errors;
	int                  pending;
	int                  idle_cycles = 0;
	logic                no_gaps = 1'b0;
	logic signed [CW-1:0] cur_org [3];
	logic signed [CW-1:0] cur_dir [3];

	always #5 clk = ~clk;

	ray_triangle_intersection u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .triangle(triangle),
		.done(done), .result(result), .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	rti_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .triangle(triangle),
		.done(done), .result(result), .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata), .errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
			6, 7:             return $signed($urandom) >>> $urandom_range(1, 30);
			default:          return $urandom;
		endcase
	endfunction

	function automatic rti_in_t rand_triangle();
		rti_in_t t;
		int      lam;
		logic signed [CW-1:0] p [3];
		logic signed [CW-1:0] w [9];
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				// build around a point on the ray so that many items hit
				lam = $urandom_range(0, 8) - 2;
				for (int i = 0; i < 3; i++)
					p[i] = cur_org[i] + lam * cur_dir[i];
				for (int i = 0; i < 9; i++)
					w[i] = p[i % 3] + $signed($urandom_range(0, 1 << 18)) - (1 << 17);
			end
			6: begin
				for (int i = 0; i < 9; i++)
					w[i] = rand_coord();
				// collapse one vertex onto another: degenerate triangle
				w[3] = w[0]; w[4] = w[1]; w[5] = w[2];
			end
			default: begin
				for (int i = 0; i < 9; i++)
					w[i] = rand_coord();
			end
		endcase
		t = '{w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8]};
		return t;
	endfunction

	// caller stands at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(input rti_in_t t);
		logic accepted;
		start <= 1'b1;
		triangle <= t;
		do begin
			accepted = !busy;
			@(negedge clk);
		end while (!accepted);
	endtask

	task automatic idle_gap();
		int gap;
		if (no_gaps)
			gap = 0;
		else case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6, 7, 8, 9: gap = 0;
			10, 11, 12, 13, 14, 15, 16, 17: gap = $urandom_range(1, 3);
			default: gap = $urandom_range(10, 60);
		endcase
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// drain first, then load all six ray registers
	task automatic load_ray(input logic signed [CW-1:0] o [3], input logic signed [CW-1:0] d [3]);
		drain();
		cur_org = o;
		cur_dir = d;
		for (int i = 0; i < 6; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_addr <= AW'(i);
			cfg_wdata <= (i < 3) ? o[i] : d[i - 3];
			@(negedge clk);
		end
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	localparam logic signed [CW-1:0] ONE  = 32'sh0001_0000;
	localparam logic signed [CW-1:0] MAXV = 32'sh7FFF_FFFF;
	localparam logic signed [CW-1:0] MINV = 32'sh8000_0000;

	initial begin
		logic signed [CW-1:0] o [3];
		logic signed [CW-1:0] d [3];
		rti_in_t t;
		cur_org = '{0, 0, 0};
		cur_dir = '{0, 0, 0};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset ray has zero direction: every item is parallel
		send_item('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
		send_item('{MAXV, MINV, MAXV, MINV, MAXV, MINV, 0, 0, 0});

		// directed: ray along +z from the origin
		load_ray('{0, 0, 0}, '{0, 0, ONE});
		send_item('{-ONE, -ONE, 5*ONE, 2*ONE, -ONE, 5*ONE, -ONE, 2*ONE, 5*ONE}); // hit
		send_item('{0, 0, 3*ONE, ONE, 0, 3*ONE, 0, ONE, 3*ONE});   // vertex on the ray
		send_item('{-ONE, 0, ONE, ONE, 0, ONE, 0, ONE, ONE});      // ray on an edge
		send_item('{ONE, ONE, ONE, 2*ONE, ONE, ONE, ONE, 2*ONE, ONE}); // miss
		send_item('{-ONE, -ONE, -4*ONE, 2*ONE, -ONE, -4*ONE, -ONE, 2*ONE, -4*ONE}); // behind
		send_item('{ONE, 0, 0, ONE, 0, 0, 0, ONE, ONE});           // degenerate triangle
		send_item('{ONE, 0, 0, ONE, ONE, 0, ONE, 0, ONE});         // plane parallel to the ray
		send_item('{MAXV, MAXV, MAXV, MINV, MINV, MINV, MAXV, MINV, MAXV});
		send_item('{MINV, MINV, MINV, MAXV, MINV, MINV, MINV, MAXV, MINV});
		send_item('{MINV, MINV, MAXV, MAXV, MINV, MAXV, MINV, MAXV, MAXV});
		send_item('{-1, -1, 1, 1, -1, 1, -1, 1, 1});               // tiny triangle
		// tiny direction, far plane: distance saturates
		load_ray('{0, 0, 0}, '{0, 0, 1});
		send_item('{MINV, MINV, MAXV, MAXV, MINV, MAXV, MINV, MAXV, MAXV});
		send_item('{MINV, MINV, MINV, MAXV, MINV, MINV, MINV, MAXV, MINV});
		send_item('{-ONE, -ONE, ONE, ONE, -ONE, ONE, -ONE, ONE, ONE});
		// extreme registers
		load_ray('{MAXV, MINV, MAXV}, '{MINV, MAXV, MINV});
		send_item('{0, 0, 0, MAXV, 0, 0, 0, MAXV, 0});
		send_item('{MINV, MAXV, MINV, 0, 0, 0, MAXV, MINV, MAXV});

		for (int ph = 0; ph < 14; ph++) begin
			case (ph % 7)
				0: begin o = '{0, 0, 0}; d = '{0, 0, ONE}; end
				1: for (int i = 0; i < 3; i++) begin
					o[i] = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
					d[i] = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
				end
				2: begin o = '{ONE, -ONE, 0}; d = '{0, 0, 0}; end
				3: begin o = '{MAXV, MAXV, MAXV}; d = '{MINV, MINV, MINV}; end
				4: begin o = '{MINV, 0, MAXV}; d = '{1, -1, 1}; end
				5: for (int i = 0; i < 3; i++) begin
					o[i] = $urandom;
					d[i] = $urandom;
				end
				default: for (int i = 0; i < 3; i++) begin
					o[i] = rand_coord();
					d[i] = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
				end
			endcase
			load_ray(o, d);
			no_gaps = (ph % 4 == 3);
			for (int n = 0; n < 100; n++) begin
				idle_gap();
				t = rand_triangle();
				send_item(t);
			end
		end

		drain();
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== ray_triangle_intersection.f =====
rtl/rti_pkg.sv
rtl/rti_det.sv
rtl/rti_div.sv
rtl/ray_triangle_intersection.sv
rtl/rti_checker.sv
bench/rti_checker.sv
bench/tb_ray_triangle_intersection.sv
